[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the block's RTL modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/apls_pkg.sv]
// ---------------------------------------------------------------------------
// apls_pkg
// Widths and controller/datapath interface types of the pair LCM stream.
// ---------------------------------------------------------------------------
package apls_pkg;

	localparam int VALUE_W = 32;
	localparam int IN_W    = 32;
	localparam int LCM_W   = 64;
	localparam int SHIFT_W = $clog2(VALUE_W);

	typedef struct packed {
		logic load;
		logic gcd_step;
		logic div_start;
		logic div_step;
		logic mul;
		logic emit1;
		logic emit2;
	} cmd_t;

	typedef struct packed {
		logic direct;
		logic gcd_done;
		logic div_last;
		logic last;
		logic out_free;
	} status_t;

endpackage

[rtl/core/apls_ctrl.sv]
// ---------------------------------------------------------------------------
// apls_ctrl
// Sequencer for one item: load, binary GCD, quotient, product, emit results.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module apls_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  apls_pkg::status_t sts,
	output apls_pkg::cmd_t   cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_GCD   = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_EMIT1 = 3'd4;
	localparam logic [2:0] ST_EMIT2 = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = sts.direct ? ST_EMIT1 : ST_GCD;
				end
			end
			ST_GCD: begin
				if (sts.gcd_done) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_EMIT1;
			end
			ST_EMIT1: begin
				if (sts.out_free) begin
					cmd.emit1 = 1'b1;
					state_d   = sts.last ? ST_EMIT2 : ST_IDLE;
				end
			end
			ST_EMIT2: begin
				if (sts.out_free) begin
					cmd.emit2 = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_RST(a_gcd_exit, clk, arst_n,
		(state_q == ST_GCD) |=> (state_q == ST_GCD || state_q == ST_DIV),
		"GCD phase left to an unexpected state")
	`ASSERT_RST(a_emit_free, clk, arst_n,
		(cmd.emit1 || cmd.emit2) |-> sts.out_free,
		"Result issued while the output register is occupied")

endmodule

[rtl/core/apls_dp.sv]
// ---------------------------------------------------------------------------
// apls_dp
// Datapath: previous value, binary GCD, restoring divider, multiplier and
// the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module apls_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [apls_pkg::IN_W-1:0]   in_value,
	input  logic                        in_first,
	input  logic                        in_last,
	input  apls_pkg::cmd_t              cmd,
	output apls_pkg::status_t           sts,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [apls_pkg::LCM_W-1:0]  m_tdata,
	output logic                        m_tlast,
	output logic [0:0]                  m_tuser
);

	localparam int VW = apls_pkg::VALUE_W;
	localparam int SW = apls_pkg::SHIFT_W;
	localparam int LW = apls_pkg::LCM_W;

	logic [VW-1:0] prev_q;
	logic [VW-1:0] x_q;
	logic [VW-1:0] cur_q;
	logic          last_q;
	logic [VW-1:0] a_q;
	logic [VW-1:0] b_q;
	logic [SW-1:0] k_q;
	logic [VW-1:0] d_q;
	logic [VW-1:0] n_q;
	logic [VW-1:0] r_q;
	logic [SW-1:0] cnt_q;
	logic [LW-1:0] term_q;
	logic          m_tvalid_q;
	logic [LW-1:0] m_tdata_q;
	logic          m_tlast_q;
	logic          m_seq_q;

	logic [VW-1:0] cur_in;
	logic [VW:0]   rem_sh;
	logic          rem_ge;
	logic [LW-1:0] prod;
	logic          out_free;

	assign cur_in   = in_value[VW-1:0];
	assign rem_sh   = {r_q, n_q[VW-1]};
	assign rem_ge   = (rem_sh >= {1'b0, d_q});
	assign prod     = LW'(n_q) * LW'(cur_q);
	assign out_free = !m_tvalid_q || m_tready;

	assign sts.direct   = in_first || (prev_q == '0) || (cur_in == '0);
	assign sts.gcd_done = (a_q == b_q);
	assign sts.div_last = (cnt_q == SW'(VW - 1));
	assign sts.last     = last_q;
	assign sts.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (cmd.load) begin
			prev_q <= cur_in;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= prev_q;
			cur_q  <= cur_in;
			last_q <= in_last;
			a_q    <= prev_q;
			b_q    <= cur_in;
			k_q    <= '0;
			term_q <= in_first ? LW'(cur_in) : '0;
		end else if (cmd.gcd_step) begin
			if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + SW'(1);
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q > b_q) begin
				a_q <= (a_q - b_q) >> 1;
			end else begin
				b_q <= (b_q - a_q) >> 1;
			end
		end else if (cmd.mul) begin
			term_q <= prod;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			d_q   <= a_q << k_q;
			n_q   <= x_q;
			r_q   <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			r_q   <= rem_ge ? VW'(rem_sh - {1'b0, d_q}) : rem_sh[VW-1:0];
			n_q   <= {n_q[VW-2:0], rem_ge};
			cnt_q <= cnt_q + SW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit1 || cmd.emit2) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit1) begin
			m_tdata_q <= term_q;
			m_tlast_q <= !last_q;
			m_seq_q   <= 1'b0;
		end else if (cmd.emit2) begin
			m_tdata_q <= LW'(cur_q);
			m_tlast_q <= 1'b1;
			m_seq_q   <= 1'b1;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tlast    = m_tlast_q;
	assign m_tuser[0] = m_seq_q;

	`ASSERT_RST(a_gcd_nonzero, clk, arst_n,
		cmd.gcd_step |-> (a_q != '0 && b_q != '0),
		"GCD stepped with a zero operand")
	`ASSERT_RST(a_rem_bound, clk, arst_n,
		cmd.div_step |-> (r_q < d_q),
		"Divider remainder not below divisor")

endmodule

[rtl/core/adjacent_pair_lcm_stream.sv]
// ---------------------------------------------------------------------------
// adjacent_pair_lcm_stream
// Streams the LCM of each adjacent pair of values, with sequence edges.
// ---------------------------------------------------------------------------
// Channel  Dir  tdata                 tuser            tlast
// s_*      in   value[31:0]           first            last
// m_*      out  lcm_value[63:0]       sequence_end     run_end
//
// An item with a first mark or a zero operand skips the GCD and the divider
// and goes from load straight to issuing its results. Otherwise the binary GCD
// and then the shift-subtract divider run before the product is formed.
// Each item issues one result, and a second one when it has a last mark.
// One item is worked at a time; the next is taken once its results are issued.
// A stalled output holds the result in the output register and the sequencer
// waits. Reset clears the sequencer, the previous value and the output valid.
// ---------------------------------------------------------------------------
module adjacent_pair_lcm_stream (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [apls_pkg::IN_W-1:0]   s_tdata,   // value
	input  logic [0:0]                  s_tuser,   // first
	input  logic                        s_tlast,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [apls_pkg::LCM_W-1:0]  m_tdata,   // lcm_value
	output logic [0:0]                  m_tuser,   // sequence_end
	output logic                        m_tlast
);

	apls_pkg::cmd_t    cmd;
	apls_pkg::status_t sts;

	apls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	apls_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_value (s_tdata),
		.in_first (s_tuser[0]),
		.in_last  (s_tlast),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
